/* hdl/fpgt_pkg.sv */
// Shared types and constants for the four-phase gait trajectory core:
// segment codes, boundaries, reciprocals, register indexes and the sine ROM.
// No dependencies.
`default_nettype none

package fpgt_pkg;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned PHASE_ONE = 1 << PHASE_W;
  localparam int unsigned BOUND_LIFT = (3 * PHASE_ONE + 5) / 10;
  localparam int unsigned BOUND_SWING = PHASE_ONE >> 1;
  localparam int unsigned BOUND_LOWER = (6 * PHASE_ONE + 5) / 10;

  localparam int unsigned LEN_LIFT = BOUND_LIFT;
  localparam int unsigned LEN_SWING = BOUND_SWING - BOUND_LIFT;
  localparam int unsigned LEN_LOWER = BOUND_LOWER - BOUND_SWING;
  localparam int unsigned LEN_PULL = PHASE_ONE - BOUND_LOWER;

  localparam int unsigned DIFF_W = 15;
  localparam int unsigned RECIP_W = 36;
  localparam int unsigned RECIP_SPLIT = 18;
  localparam int unsigned PART_W = DIFF_W + RECIP_SPLIT;
  localparam int unsigned PROD_W = PART_W + RECIP_SPLIT + 1;
  localparam int unsigned RECIP_SHIFT = 32;

  localparam logic [63:0] RECIP_NUM = 64'd1 << 48;
  localparam logic [RECIP_W-1:0] RECIP_LIFT =
      RECIP_W'((RECIP_NUM + 64'(LEN_LIFT) - 64'd1) / 64'(LEN_LIFT));
  localparam logic [RECIP_W-1:0] RECIP_SWING =
      RECIP_W'((RECIP_NUM + 64'(LEN_SWING) - 64'd1) / 64'(LEN_SWING));
  localparam logic [RECIP_W-1:0] RECIP_LOWER =
      RECIP_W'((RECIP_NUM + 64'(LEN_LOWER) - 64'd1) / 64'(LEN_LOWER));
  localparam logic [RECIP_W-1:0] RECIP_PULL =
      RECIP_W'((RECIP_NUM + 64'(LEN_PULL) - 64'd1) / 64'(LEN_PULL));

  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [16:0] STRIDE_LIFT_Q16 = 17'd19661;
  localparam logic [16:0] STRIDE_SWING_Q16 = 17'd45875;
  localparam logic [15:0] FRAC_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    SEG_LIFT,
    SEG_SWING,
    SEG_LOWER,
    SEG_PULL
  } seg_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LIFT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RETRACT = 3'd5;

  localparam logic signed [14:0] HOME_X_RESET = 15'sd12704;
  localparam logic signed [14:0] HOME_Y_RESET = 15'sd0;
  localparam logic signed [14:0] HOME_Z_RESET = -15'sd3206;
  localparam logic [12:0] STRIDE_RESET = 13'd4480;
  localparam logic [12:0] LIFT_RESET = 13'd3603;
  localparam logic [11:0] RETRACT_RESET = 12'd1280;

  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IDX_PROD_W = PHASE_W + $clog2(SINE_TABLE_DEPTH) + 1;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic [SINE_TABLE_DEPTH:0][16:0] sine_rom_t;

  function automatic logic [16:0] sine_entry(input int unsigned k);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] v;
    logic signed [63:0] sum;
    a = (64'(k) * PI_HALF_Q30) / 64'(SINE_TABLE_DEPTH);
    a2 = (a * a) >> 30;
    term = a;
    sum = signed'(a);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (unsigned'(sum) + 64'd8192) >> 14;
    if (v > 64'd65536 || k == SINE_TABLE_DEPTH) begin
      v = 64'd65536;
    end
    return v[16:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      r[k] = sine_entry(k);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      return -16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/four_phase_gait_trajectory_core.sv */
// Four-phase gait trajectory core: phase in, foot position out, seven stages.
// Depends on fpgt_pkg for segment constants, reciprocals and the sine ROM.
//
// Usage:
//   Slave stream s_tdata[15:0] carries gait_phase, an unsigned Q0.16 fraction
//   of one gait cycle. Master stream m_tdata carries foot_x [15:0],
//   foot_y [31:16] and foot_z [47:32], signed, 1/64 mm, saturated.
//   The cfg port writes the six trajectory registers (home x/y/z, stride,
//   lift, retraction); write only while no request is in flight.
//   One request is taken every cycle while the output is not stalled; the
//   rate is set by the stage chain of segment select, split reciprocal
//   multiply, partial combine and clamp, ROM index rounding, ROM lookup,
//   scaling multiply and saturation, each one register stage deep.
//   Every stage has its own valid bit and hold enable, so bubbles collapse
//   and a stalled m_tready backs up stage by stage; s_tready drops only
//   when all seven stages hold a request.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults; the ROM is constant and needs no fill.
`default_nettype none

module four_phase_gait_trajectory_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,   // gait_phase
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [47:0]                         m_tdata,   // foot_x, foot_y, foot_z
  input  wire logic                           cfg_we,
  input  wire logic [fpgt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fpgt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned NSTAGE = 7;

  logic signed [14:0] home_x;
  logic signed [14:0] home_y;
  logic signed [14:0] home_z;
  logic [12:0]        stride_dist;
  logic [12:0]        lift_amp;
  logic [11:0]        retraction;

  logic [NSTAGE:1] valid;
  logic [NSTAGE:1] en;

  fpgt_pkg::seg_t                    s1_seg;
  logic [fpgt_pkg::DIFF_W-1:0]       s1_diff;
  logic [fpgt_pkg::RECIP_W-1:0]      s1_recip;

  fpgt_pkg::seg_t                    s2_seg;
  logic [fpgt_pkg::PART_W-1:0]       s2_plo;
  logic [fpgt_pkg::PART_W-1:0]       s2_phi;

  fpgt_pkg::seg_t                    s3_seg;
  logic [15:0]                       s3_frac;

  fpgt_pkg::seg_t                    s4_seg;
  logic [15:0]                       s4_frac;
  logic [fpgt_pkg::SINE_IDX_W-1:0]   s4_idx;
  logic [16:0]                       s4_stride;

  fpgt_pkg::seg_t                    s5_seg;
  logic [16:0]                       s5_xfac;
  logic [16:0]                       s5_zfac;
  logic [16:0]                       s5_stride;

  logic [12:0]                       s6_offx;
  logic [13:0]                       s6_offy;
  logic [13:0]                       s6_offz;

  logic signed [15:0]                out_x;
  logic signed [15:0]                out_y;
  logic signed [15:0]                out_z;

  fpgt_pkg::seg_t                    seg_in;
  logic [fpgt_pkg::DIFF_W-1:0]       diff_in;
  logic [fpgt_pkg::RECIP_W-1:0]      recip_in;
  logic [fpgt_pkg::PROD_W-1:0]       prod;
  logic [fpgt_pkg::PROD_W-fpgt_pkg::RECIP_SHIFT-1:0] quot;
  logic [15:0]                       frac_next;
  logic [fpgt_pkg::IDX_PROD_W-1:0]   idx_prod;
  logic [32:0]                       lift_prod;
  logic [32:0]                       swing_prod;
  logic [16:0]                       stride_next;
  logic [fpgt_pkg::SINE_IDX_W-1:0]   rom_addr;
  logic [16:0]                       rom_data;
  logic [16:0]                       xfac_next;
  logic [16:0]                       zfac_next;
  logic [29:0]                       offx_prod;
  logic [30:0]                       offy_prod;
  logic [30:0]                       offz_prod;
  logic signed [16:0]                sum_x;
  logic signed [16:0]                sum_y;
  logic signed [16:0]                sum_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      home_x      <= fpgt_pkg::HOME_X_RESET;
      home_y      <= fpgt_pkg::HOME_Y_RESET;
      home_z      <= fpgt_pkg::HOME_Z_RESET;
      stride_dist <= fpgt_pkg::STRIDE_RESET;
      lift_amp    <= fpgt_pkg::LIFT_RESET;
      retraction  <= fpgt_pkg::RETRACT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpgt_pkg::REG_HOME_X:  home_x      <= signed'(cfg_data);
        fpgt_pkg::REG_HOME_Y:  home_y      <= signed'(cfg_data);
        fpgt_pkg::REG_HOME_Z:  home_z      <= signed'(cfg_data);
        fpgt_pkg::REG_STRIDE:  stride_dist <= cfg_data[12:0];
        fpgt_pkg::REG_LIFT:    lift_amp    <= cfg_data[12:0];
        fpgt_pkg::REG_RETRACT: retraction  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // stage hold enables, last stage first
  always_comb begin
    en[NSTAGE] = !valid[NSTAGE] || m_tready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[1]) begin
        valid[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // stage 1: segment select, offset into segment, reciprocal
  always_comb begin
    if (s_tdata < 16'(fpgt_pkg::BOUND_LIFT)) begin
      seg_in   = fpgt_pkg::SEG_LIFT;
      diff_in  = s_tdata[fpgt_pkg::DIFF_W-1:0];
      recip_in = fpgt_pkg::RECIP_LIFT;
    end else if (s_tdata < 16'(fpgt_pkg::BOUND_SWING)) begin
      seg_in   = fpgt_pkg::SEG_SWING;
      diff_in  = fpgt_pkg::DIFF_W'(s_tdata - 16'(fpgt_pkg::BOUND_LIFT));
      recip_in = fpgt_pkg::RECIP_SWING;
    end else if (s_tdata < 16'(fpgt_pkg::BOUND_LOWER)) begin
      seg_in   = fpgt_pkg::SEG_LOWER;
      diff_in  = fpgt_pkg::DIFF_W'(s_tdata - 16'(fpgt_pkg::BOUND_SWING));
      recip_in = fpgt_pkg::RECIP_LOWER;
    end else begin
      seg_in   = fpgt_pkg::SEG_PULL;
      diff_in  = fpgt_pkg::DIFF_W'(s_tdata - 16'(fpgt_pkg::BOUND_LOWER));
      recip_in = fpgt_pkg::RECIP_PULL;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_seg   <= seg_in;
      s1_diff  <= diff_in;
      s1_recip <= recip_in;
    end
  end

  // stage 2: reciprocal multiply as two partial products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_seg <= s1_seg;
      s2_plo <= fpgt_pkg::PART_W'(s1_diff) *
                fpgt_pkg::PART_W'(s1_recip[fpgt_pkg::RECIP_SPLIT-1:0]);
      s2_phi <= fpgt_pkg::PART_W'(s1_diff) *
                fpgt_pkg::PART_W'(s1_recip[fpgt_pkg::RECIP_W-1:fpgt_pkg::RECIP_SPLIT]);
    end
  end

  // stage 3: combine partials, scale down, clamp
  always_comb begin
    prod = {1'b0, s2_phi, {fpgt_pkg::RECIP_SPLIT{1'b0}}} + fpgt_pkg::PROD_W'(s2_plo);
    quot = prod[fpgt_pkg::PROD_W-1:fpgt_pkg::RECIP_SHIFT];
    if (quot > $bits(quot)'(fpgt_pkg::FRAC_MAX)) begin
      frac_next = fpgt_pkg::FRAC_MAX;
    end else begin
      frac_next = quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_seg  <= s2_seg;
      s3_frac <= frac_next;
    end
  end

  // stage 4: ROM index and stride fraction
  always_comb begin
    idx_prod   = fpgt_pkg::IDX_PROD_W'(s3_frac) *
                 fpgt_pkg::IDX_PROD_W'(fpgt_pkg::SINE_TABLE_DEPTH) +
                 fpgt_pkg::IDX_PROD_W'(32768);
    lift_prod  = 33'(fpgt_pkg::STRIDE_LIFT_Q16) * 33'(s3_frac) + 33'd32768;
    swing_prod = 33'(fpgt_pkg::STRIDE_SWING_Q16) * 33'(s3_frac) + 33'd32768;
    case (s3_seg)
      fpgt_pkg::SEG_LIFT:  stride_next = 17'(lift_prod[31:16]);
      fpgt_pkg::SEG_SWING: stride_next = fpgt_pkg::STRIDE_LIFT_Q16 + 17'(swing_prod[31:16]);
      fpgt_pkg::SEG_LOWER: stride_next = fpgt_pkg::Q16_ONE;
      default:             stride_next = fpgt_pkg::Q16_ONE - 17'(s3_frac);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_seg    <= s3_seg;
      s4_frac   <= s3_frac;
      s4_idx    <= idx_prod[fpgt_pkg::IDX_PROD_W-1:16];
      s4_stride <= stride_next;
    end
  end

  // stage 5: sine or cosine lookup, per-axis factors
  always_comb begin
    if (s4_seg == fpgt_pkg::SEG_SWING) begin
      rom_addr = fpgt_pkg::SINE_IDX_W'(fpgt_pkg::SINE_TABLE_DEPTH) - s4_idx;
    end else begin
      rom_addr = s4_idx;
    end
    rom_data = fpgt_pkg::SINE_ROM[rom_addr];
    case (s4_seg)
      fpgt_pkg::SEG_LIFT: begin
        xfac_next = rom_data;
        zfac_next = rom_data;
      end
      fpgt_pkg::SEG_SWING: begin
        xfac_next = rom_data;
        zfac_next = fpgt_pkg::Q16_ONE;
      end
      fpgt_pkg::SEG_LOWER: begin
        xfac_next = '0;
        zfac_next = fpgt_pkg::Q16_ONE - 17'(s4_frac);
      end
      default: begin
        xfac_next = '0;
        zfac_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_seg    <= s4_seg;
      s5_xfac   <= xfac_next;
      s5_zfac   <= zfac_next;
      s5_stride <= s4_stride;
    end
  end

  // stage 6: scale magnitudes, round half up
  always_comb begin
    offx_prod = 30'(retraction) * 30'(s5_xfac) + 30'd32768;
    offy_prod = 31'(stride_dist) * 31'(s5_stride) + 31'd32768;
    offz_prod = 31'(lift_amp) * 31'(s5_zfac) + 31'd32768;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_offx <= offx_prod[28:16];
      s6_offy <= offy_prod[29:16];
      s6_offz <= offz_prod[29:16];
    end
  end

  // stage 7: apply to home, saturate
  always_comb begin
    sum_x = 17'(home_x) - signed'({4'b0, s6_offx});
    sum_y = 17'(home_y) - signed'({3'b0, s6_offy});
    sum_z = 17'(home_z) + signed'({3'b0, s6_offz});
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_x <= fpgt_pkg::sat16(sum_x);
      out_y <= fpgt_pkg::sat16(sum_y);
      out_z <= fpgt_pkg::sat16(sum_z);
    end
  end

  assign m_tvalid = valid[NSTAGE];
  assign m_tdata  = {out_z, out_y, out_x};

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    ($countones(valid) == NSTAGE && !m_tready) |-> !s_tready)
    else $error("request taken while pipeline full and stalled");

  a_rom_bound : assert property (@(posedge clk) disable iff (rst)
    valid[5] |-> (s5_xfac <= fpgt_pkg::Q16_ONE && s5_zfac <= fpgt_pkg::Q16_ONE))
    else $error("trajectory factor above one");

  a_flat_x : assert property (@(posedge clk) disable iff (rst)
    (valid[5] && (s5_seg == fpgt_pkg::SEG_LOWER || s5_seg == fpgt_pkg::SEG_PULL))
      |-> s5_xfac == '0)
    else $error("x retraction outside lift and swing");

endmodule

`default_nettype wire

/* tb/four_phase_gait_trajectory_core_tb.sv */
// Self-checking bench for four_phase_gait_trajectory_core: streams gait phases,
// predicts foot x/y/z per request, checks results in order across register settings.
// Depends on fpgt_pkg for the config port widths and register indexes.

module four_phase_gait_trajectory_core_tb;

  localparam int unsigned PHASE_FULL = 65536;
  localparam int unsigned LIFT_END = (3 * PHASE_FULL + 5) / 10;
  localparam int unsigned SWING_END = PHASE_FULL / 2;
  localparam int unsigned LOWER_END = (6 * PHASE_FULL + 5) / 10;
  localparam int unsigned SINE_DEPTH = 256;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int PIPE_LATENCY = 7;
  localparam int PHASE_COUNT = 8;
  localparam int RANDOM_PER_PHASE = 54;
  localparam logic [fpgt_pkg::CFG_INDEX_W-1:0] FIRST_SPARE_REG =
      fpgt_pkg::REG_RETRACT + 1'b1;
  localparam logic [fpgt_pkg::CFG_INDEX_W-1:0] LAST_SPARE_REG = '1;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } foot_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;   // gait_phase
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;        // foot_x, foot_y, foot_z
  logic cfg_we = 1'b0;
  logic [fpgt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fpgt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [14:0] home_x_r = 15'sd12704;
  logic signed [14:0] home_y_r = 15'sd0;
  logic signed [14:0] home_z_r = -15'sd3206;
  logic [12:0] stride_r = 13'd4480;
  logic [12:0] lift_r = 13'd3603;
  logic [11:0] retract_r = 12'd1280;

  logic [16:0] sine_q16 [0:SINE_DEPTH];
  logic [15:0] pending_phase_q [$];
  foot_pos_t expected_foot_q [$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int sender_idle_by_mode [4] = '{0, 67, 0, 28};
  int recv_stall_by_mode [4] = '{0, 0, 67, 28};
  logic [15:0] boundary_phases [13] = '{
    16'd0, 16'd1, 16'(LIFT_END - 1), 16'(LIFT_END), 16'(LIFT_END + 1),
    16'(SWING_END - 1), 16'(SWING_END), 16'(SWING_END + 1),
    16'(LOWER_END - 1), 16'(LOWER_END), 16'(LOWER_END + 1), 16'd65534, 16'd65535
  };

  four_phase_gait_trajectory_core u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned segment_fraction(input longint unsigned d,
                                                       input longint unsigned len);
    longint unsigned recip;
    longint unsigned p;
    recip = ((64'd1 << 48) + len - 1) / len;
    p = (d * recip) >> 32;
    return (p > 65535) ? 65535 : p;
  endfunction

  function automatic longint round_scale(input longint unsigned mag, input longint unsigned q16);
    return longint'((mag * q16 + 32768) >> 16);
  endfunction

  function automatic logic signed [15:0] saturate16(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic foot_pos_t foot_position(input logic [15:0] phase);
    longint unsigned t;
    longint unsigned p;
    longint unsigned idx;
    longint unsigned f;
    longint x;
    longint y;
    longint z;
    foot_pos_t r;
    t = phase;
    x = home_x_r;
    y = home_y_r;
    z = home_z_r;
    if (t < LIFT_END) begin
      p = segment_fraction(t, LIFT_END);
      idx = (p * SINE_DEPTH + 32768) >> 16;
      x = x - round_scale(retract_r, sine_q16[idx]);
      z = z + round_scale(lift_r, sine_q16[idx]);
      f = (19661 * p + 32768) >> 16;
    end else if (t < SWING_END) begin
      p = segment_fraction(t - LIFT_END, SWING_END - LIFT_END);
      idx = (p * SINE_DEPTH + 32768) >> 16;
      x = x - round_scale(retract_r, sine_q16[SINE_DEPTH - idx]);
      z = z + longint'(lift_r);
      f = 19661 + ((45875 * p + 32768) >> 16);
    end else if (t < LOWER_END) begin
      p = segment_fraction(t - SWING_END, LOWER_END - SWING_END);
      z = z + round_scale(lift_r, 65536 - p);
      f = 65536;
    end else begin
      p = segment_fraction(t - LOWER_END, PHASE_FULL - LOWER_END);
      f = 65536 - p;
    end
    y = y - round_scale(stride_r, f);
    r.x = saturate16(x);
    r.y = saturate16(y);
    r.z = saturate16(z);
    return r;
  endfunction

  function automatic logic [15:0] pick_phase();
    if ($urandom_range(4) == 0) begin
      return boundary_phases[$urandom_range(12)] + 16'($urandom_range(6)) - 16'd3;
    end
    return 16'($urandom_range(65535));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_foot_q.push_back(foot_position(s_tdata));
        void'(pending_phase_q.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_phase_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_phase_q[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    foot_pos_t want;
    foot_pos_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_foot_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
          end
        end else begin
          want = expected_foot_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
            end
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [fpgt_pkg::CFG_INDEX_W-1:0] index,
                           input logic [fpgt_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      fpgt_pkg::REG_HOME_X: home_x_r = data;
      fpgt_pkg::REG_HOME_Y: home_y_r = data;
      fpgt_pkg::REG_HOME_Z: home_z_r = data;
      fpgt_pkg::REG_STRIDE: stride_r = data[12:0];
      fpgt_pkg::REG_LIFT: lift_r = data[12:0];
      fpgt_pkg::REG_RETRACT: retract_r = data[11:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_phase_q.size() != 0 || s_tvalid || expected_foot_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned v;
    longint sum;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      a = longint'(k) * QUARTER_TURN_Q30 / SINE_DEPTH;
      a2 = (a * a) >> 30;
      term = a;
      sum = longint'(a);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
        sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) + 8192) >> 14;
      if (v > 65536 || k == SINE_DEPTH) begin
        v = 65536;
      end
      sine_q16[k] = v[16:0];
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (boundary_phases[i]) pending_phase_q.push_back(boundary_phases[i]);
    pending_phase_q.push_back(16'd9830);
    pending_phase_q.push_back(16'd26214);
    pending_phase_q.push_back(16'd36045);
    pending_phase_q.push_back(16'd52428);
    pending_phase_q.push_back(16'h5555);
    pending_phase_q.push_back(16'hAAAA);
    drain();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          write_reg(fpgt_pkg::REG_HOME_X, 15'h3FFF);
          write_reg(fpgt_pkg::REG_HOME_Y, 15'h3FFF);
          write_reg(fpgt_pkg::REG_HOME_Z, 15'h3FFF);
          write_reg(fpgt_pkg::REG_STRIDE, 15'd8191);
          write_reg(fpgt_pkg::REG_LIFT, 15'd8191);
          write_reg(fpgt_pkg::REG_RETRACT, 15'd4095);
        end
        1: begin
          write_reg(fpgt_pkg::REG_HOME_X, 15'h4000);
          write_reg(fpgt_pkg::REG_HOME_Y, 15'h4000);
          write_reg(fpgt_pkg::REG_HOME_Z, 15'h4000);
          write_reg(fpgt_pkg::REG_STRIDE, 15'd0);
          write_reg(fpgt_pkg::REG_LIFT, 15'd0);
          write_reg(fpgt_pkg::REG_RETRACT, 15'd0);
        end
        2: begin
          for (int r = int'(fpgt_pkg::REG_HOME_X); r <= int'(fpgt_pkg::REG_RETRACT); r++) begin
            write_reg(fpgt_pkg::CFG_INDEX_W'(r), 15'($urandom_range(32767)));
          end
          write_reg(fpgt_pkg::REG_STRIDE, 15'h7FFF);
          write_reg(fpgt_pkg::REG_LIFT, 15'h7FFF);
          write_reg(fpgt_pkg::REG_RETRACT, 15'h7FFF);
        end
        default: begin
          write_reg(fpgt_pkg::REG_HOME_X, 15'($urandom_range(32767)));
          write_reg(fpgt_pkg::REG_HOME_Y, 15'($urandom_range(32767)));
          write_reg(fpgt_pkg::REG_HOME_Z, 15'($urandom_range(32767)));
          write_reg(fpgt_pkg::REG_STRIDE, 15'($urandom_range(8191)));
          write_reg(fpgt_pkg::REG_LIFT, 15'($urandom_range(8191)));
          write_reg(fpgt_pkg::REG_RETRACT, 15'($urandom_range(4095)));
        end
      endcase
      write_reg(fpgt_pkg::CFG_INDEX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
                15'($urandom_range(32767)));
      end_writes();

      @(negedge clk);
      sender_idle_pct = sender_idle_by_mode[ph % 4];
      recv_stall_pct = recv_stall_by_mode[ph % 4];
      foreach (boundary_phases[i]) pending_phase_q.push_back(boundary_phases[i]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pending_phase_q.push_back(pick_phase());
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("four_phase_gait_trajectory_core_tb OK");
    end else begin
      $display("four_phase_gait_trajectory_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("four_phase_gait_trajectory_core_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
hdl/fpgt_pkg.sv
hdl/four_phase_gait_trajectory_core.sv
tb/four_phase_gait_trajectory_core_tb.sv
